>>> hdl/dsfz_pkg.sv
// dsfz_pkg: shared types and constants for the dual sensor fault and zone classifier
// no dependencies; used by hdl/dual_sensor_fault_and_zone_classifier.sv
`timescale 1ns / 1ps
`default_nettype none

package dsfz_pkg;

  localparam int unsigned SampleBits = 12;
  localparam int unsigned TimeBits   = 32;
  localparam int unsigned WindowBits = 4 * SampleBits;
  localparam int unsigned NumChan    = 2;

  // apb register map, 64-bit data, registers on 8-byte strides
  localparam int unsigned ApbDataBits = 64;
  localparam int unsigned ApbAddrBits = 6;
  localparam int unsigned RegIdxBits  = 3;

  typedef enum logic [RegIdxBits-1:0] {
    RegFaultLevel  = 3'd0,
    RegConfirmTime = 3'd1,
    RegZoneA       = 3'd2,
    RegZoneB       = 3'd3,
    RegZoneC       = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ZoneA       = 2'd0,
    ZoneB       = 2'd1,
    ZoneC       = 2'd2,
    ZoneOnStage = 2'd3
  } zone_e;

  localparam logic [SampleBits-1:0] FaultLevelReset  = '1;
  localparam logic [TimeBits-1:0]   ConfirmTimeReset = 32'd1000;

  typedef logic [SampleBits-1:0] code_t;
  typedef logic [TimeBits-1:0]   time_t;
  typedef logic [WindowBits-1:0] window_t;

  typedef struct packed {
    code_t sample_ch0;
    code_t sample_ch1;
    time_t now_ms;
  } in_item_t;

  typedef struct packed {
    logic       fault_ch0;
    logic       fault_ch1;
    logic       sensor_ok;
    logic [1:0] zone;
    logic       off_stage;
  } out_item_t;

endpackage

`default_nettype wire

>>> hdl/dual_sensor_fault_and_zone_classifier.sv
// top level: per-channel fault timers, three-window zone classifier, apb register file
// depends on hdl/dsfz_pkg.sv
//
//  port group   direction  handshake                 payload
//  in_*         input      in_valid_i / in_ready_o   in_data_i  (dsfz_pkg::in_item_t)
//  out_*        output     out_valid_o / out_ready_i out_data_o (dsfz_pkg::out_item_t)
//  apb          in / out   psel, penable / pready    pwrite, paddr, pwdata / prdata (64 bit)
//
//  one transaction per cycle sustained while out_ready_i keeps the result register draining
//  a transaction is captured in the input register, then classified and written to the
//  result register, updating the fault timers in the same cycle
//  in_ready_o stays high while the result register is empty or being drained
//  reset clears the timers, fault flags and valid bits, and loads register defaults
`timescale 1ns / 1ps
`default_nettype none

module dual_sensor_fault_and_zone_classifier (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                in_valid_i,
  output      logic                                in_ready_o,
  input  wire dsfz_pkg::in_item_t                  in_data_i,

  output      logic                                out_valid_o,
  input  wire logic                                out_ready_i,
  output      dsfz_pkg::out_item_t                 out_data_o,

  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [dsfz_pkg::ApbAddrBits-1:0]    paddr,
  input  wire logic [dsfz_pkg::ApbDataBits-1:0]    pwdata,
  output      logic [dsfz_pkg::ApbDataBits-1:0]    prdata,
  output      logic                                pready
);

  // ---------------- register file
  dsfz_pkg::code_t   level_q;
  dsfz_pkg::time_t   confirm_q;
  dsfz_pkg::window_t win_q [3];

  dsfz_pkg::reg_idx_e reg_idx;
  logic               reg_wr;

  assign pready  = 1'b1;
  assign reg_idx = dsfz_pkg::reg_idx_e'(paddr[dsfz_pkg::ApbAddrBits-1:3]);
  assign reg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q   <= dsfz_pkg::FaultLevelReset;
      confirm_q <= dsfz_pkg::ConfirmTimeReset;
      win_q[0]  <= '0;
      win_q[1]  <= '0;
      win_q[2]  <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        dsfz_pkg::RegFaultLevel:  level_q   <= pwdata[dsfz_pkg::SampleBits-1:0];
        dsfz_pkg::RegConfirmTime: confirm_q <= pwdata[dsfz_pkg::TimeBits-1:0];
        dsfz_pkg::RegZoneA:       win_q[0]  <= pwdata[dsfz_pkg::WindowBits-1:0];
        dsfz_pkg::RegZoneB:       win_q[1]  <= pwdata[dsfz_pkg::WindowBits-1:0];
        dsfz_pkg::RegZoneC:       win_q[2]  <= pwdata[dsfz_pkg::WindowBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dsfz_pkg::RegFaultLevel:
        prdata = {{(dsfz_pkg::ApbDataBits-dsfz_pkg::SampleBits){1'b0}}, level_q};
      dsfz_pkg::RegConfirmTime:
        prdata = {{(dsfz_pkg::ApbDataBits-dsfz_pkg::TimeBits){1'b0}}, confirm_q};
      dsfz_pkg::RegZoneA:
        prdata = {{(dsfz_pkg::ApbDataBits-dsfz_pkg::WindowBits){1'b0}}, win_q[0]};
      dsfz_pkg::RegZoneB:
        prdata = {{(dsfz_pkg::ApbDataBits-dsfz_pkg::WindowBits){1'b0}}, win_q[1]};
      dsfz_pkg::RegZoneC:
        prdata = {{(dsfz_pkg::ApbDataBits-dsfz_pkg::WindowBits){1'b0}}, win_q[2]};
      default:
        prdata = '0;
    endcase
  end

  // ---------------- input register
  logic               s1_valid_q;
  dsfz_pkg::in_item_t s1_data_q;
  logic               s1_adv;
  logic               out_valid_q;
  dsfz_pkg::out_item_t out_data_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_data_q <= in_data_i;
    end
  end

  // ---------------- fault timers and zone match
  logic            armed_q [dsfz_pkg::NumChan];
  logic            armed_d [dsfz_pkg::NumChan];
  dsfz_pkg::time_t start_q [dsfz_pkg::NumChan];
  dsfz_pkg::time_t start_d [dsfz_pkg::NumChan];
  logic            fault_q [dsfz_pkg::NumChan];
  logic            fault_d [dsfz_pkg::NumChan];

  dsfz_pkg::code_t code    [dsfz_pkg::NumChan];
  dsfz_pkg::time_t elapsed [dsfz_pkg::NumChan];
  logic            win_hit [3];
  logic            sensor_ok;
  dsfz_pkg::zone_e zone;
  dsfz_pkg::out_item_t result;

  assign code[0] = s1_data_q.sample_ch0;
  assign code[1] = s1_data_q.sample_ch1;

  always_comb begin
    for (int c = 0; c < dsfz_pkg::NumChan; c++) begin
      armed_d[c] = armed_q[c];
      start_d[c] = start_q[c];
      fault_d[c] = fault_q[c];
      elapsed[c] = s1_data_q.now_ms - start_q[c];
      if (code[c] >= level_q) begin
        if (!armed_q[c]) begin
          // first high sample only arms the timer
          armed_d[c] = 1'b1;
          start_d[c] = s1_data_q.now_ms;
        end else if (elapsed[c] >= confirm_q) begin
          fault_d[c] = 1'b1;
        end
      end else begin
        armed_d[c] = 1'b0;
        start_d[c] = '0;
        fault_d[c] = 1'b0;
      end
    end
  end

  // a faulted channel counts as inside every window
  always_comb begin
    for (int w = 0; w < 3; w++) begin
      win_hit[w] =
        (fault_d[0] ||
         (code[0] >= win_q[w][0*dsfz_pkg::SampleBits +: dsfz_pkg::SampleBits] &&
          code[0] <= win_q[w][1*dsfz_pkg::SampleBits +: dsfz_pkg::SampleBits])) &&
        (fault_d[1] ||
         (code[1] >= win_q[w][2*dsfz_pkg::SampleBits +: dsfz_pkg::SampleBits] &&
          code[1] <= win_q[w][3*dsfz_pkg::SampleBits +: dsfz_pkg::SampleBits]));
    end
  end

  assign sensor_ok = !(fault_d[0] && fault_d[1]);

  always_comb begin
    if (sensor_ok && win_hit[0]) begin
      zone = dsfz_pkg::ZoneA;
    end else if (sensor_ok && win_hit[1]) begin
      zone = dsfz_pkg::ZoneB;
    end else if (sensor_ok && win_hit[2]) begin
      zone = dsfz_pkg::ZoneC;
    end else begin
      zone = dsfz_pkg::ZoneOnStage;
    end
  end

  always_comb begin
    result.fault_ch0 = fault_d[0];
    result.fault_ch1 = fault_d[1];
    result.sensor_ok = sensor_ok;
    result.zone      = zone;
    result.off_stage = (zone != dsfz_pkg::ZoneOnStage);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < dsfz_pkg::NumChan; c++) begin
        armed_q[c] <= 1'b0;
        start_q[c] <= '0;
        fault_q[c] <= 1'b0;
      end
    end else if (s1_adv) begin
      for (int c = 0; c < dsfz_pkg::NumChan; c++) begin
        armed_q[c] <= armed_d[c];
        start_q[c] <= start_d[c];
        fault_q[c] <= fault_d[c];
      end
    end
  end

  // ---------------- result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // ---------------- assertions
  a_fault_needs_arm0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q[0] |-> armed_q[0])
    else $error("channel 0 fault set without armed timer");

  a_fault_needs_arm1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fault_q[1] |-> armed_q[1])
    else $error("channel 1 fault set without armed timer");

  a_fault_rise_after_arm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fault_q[0]) |-> $past(armed_q[0]))
    else $error("channel 0 fault latched on the arming transaction");

  a_ok_matches_faults: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.sensor_ok == !(out_data_o.fault_ch0 && out_data_o.fault_ch1)))
    else $error("sensor_ok disagrees with fault flags");

  a_both_faulted_on_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.sensor_ok) |->
      (out_data_o.zone == dsfz_pkg::ZoneOnStage && !out_data_o.off_stage))
    else $error("zone reported while both channels faulted");

  a_result_on_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_valid_o)
    else $error("result register did not load");

endmodule

`default_nettype wire

>>> test/tb_dual_sensor_fault_and_zone_classifier.sv
// testbench for dual_sensor_fault_and_zone_classifier: directed table, then random phases
// each phase uses new register settings; results are checked against an in-file predictor
// depends on hdl/dsfz_pkg.sv and hdl/dual_sensor_fault_and_zone_classifier.sv
`timescale 1ns / 1ps

module tb_dual_sensor_fault_and_zone_classifier;
  import dsfz_pkg::*;

  localparam int unsigned CodeMax       = (1 << SampleBits) - 1;
  localparam int unsigned RegStride     = ApbDataBits / 8;
  localparam int unsigned NumRegs       = RegZoneC + 1;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned PhaseItems    = 45;
  localparam int unsigned MaxGap        = 18;
  localparam int unsigned DrainCycles   = 6;
  localparam int unsigned LongHold      = 160;
  localparam int unsigned WatchdogLimit = 2000;

  typedef enum logic [1:0] {
    RowItem,
    RowCheck,
    RowWrite
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [RegIdxBits-1:0]    reg_i;
    logic [ApbDataBits-1:0]   arg;
    in_item_t                 item;
    out_item_t                want;
  } dir_row_t;

  typedef struct packed {
    logic      typed;
    out_item_t want;
  } sent_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  in_item_t               in_data_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  out_item_t              out_data_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  dual_sensor_fault_and_zone_classifier u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // register mirror and fault timer state of the predictor
  code_t   level_code = FaultLevelReset;
  time_t   confirm_ms = ConfirmTimeReset;
  window_t zone_win [3] = '{default: '0};
  zone_e   win_zone [3] = '{ZoneA, ZoneB, ZoneC};
  logic    armed   [NumChan] = '{default: 1'b0};
  time_t   arm_ms  [NumChan] = '{default: '0};
  logic    faulted [NumChan] = '{default: 1'b0};

  out_item_t   want_q [$];
  sent_t       sent_q [$];
  dir_row_t    dir_tab [$];

  int unsigned n_err = 0;
  int unsigned n_sent = 0;
  int unsigned n_out = 0;
  int unsigned n_cfg = 0;
  int unsigned n_fault = 0;
  int unsigned zone_seen [4] = '{default: 0};
  int unsigned quiet = 0;

  // random stimulus state
  time_t       tick = '0;
  logic        hi_run   [NumChan] = '{default: 1'b0};
  int unsigned run_left [NumChan] = '{default: 0};

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic in_window(window_t w, code_t c0, code_t c1);
    code_t code [NumChan];
    logic  hit;
    code[0] = c0;
    code[1] = c1;
    hit = 1'b1;
    for (int ch = 0; ch < NumChan; ch++) begin
      if (!faulted[ch] && !(code[ch] >= w[2*ch*SampleBits +: SampleBits] &&
                            code[ch] <= w[(2*ch+1)*SampleBits +: SampleBits])) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // updates the fault timers and classifies one sample pair
  function automatic out_item_t classify(in_item_t it);
    code_t     code [NumChan];
    out_item_t r;
    zone_e     z;
    logic      ok;
    code[0] = it.sample_ch0;
    code[1] = it.sample_ch1;
    for (int ch = 0; ch < NumChan; ch++) begin
      if (code[ch] >= level_code) begin
        if (!armed[ch]) begin
          armed[ch]  = 1'b1;
          arm_ms[ch] = it.now_ms;
        end else if (time_t'(it.now_ms - arm_ms[ch]) >= confirm_ms) begin
          faulted[ch] = 1'b1;
        end
      end else begin
        armed[ch]   = 1'b0;
        arm_ms[ch]  = '0;
        faulted[ch] = 1'b0;
      end
    end
    ok = !(faulted[0] && faulted[1]);
    z  = ZoneOnStage;
    // walk from lowest priority so the highest matching window wins
    if (ok) begin
      for (int k = 2; k >= 0; k--) begin
        if (in_window(zone_win[k], code[0], code[1])) z = win_zone[k];
      end
    end
    r.fault_ch0 = faulted[0];
    r.fault_ch1 = faulted[1];
    r.sensor_ok = ok;
    r.zone      = z;
    r.off_stage = (z != ZoneOnStage);
    return r;
  endfunction

  function automatic in_item_t mk_in(int unsigned c0, int unsigned c1, time_t t);
    in_item_t it;
    it.sample_ch0 = code_t'(c0);
    it.sample_ch1 = code_t'(c1);
    it.now_ms     = t;
    return it;
  endfunction

  function automatic dir_row_t mk_item(int unsigned c0, int unsigned c1, time_t t);
    dir_row_t row;
    row      = '0;
    row.kind = RowItem;
    row.item = mk_in(c0, c1, t);
    return row;
  endfunction

  function automatic dir_row_t mk_check(int unsigned c0, int unsigned c1, time_t t,
                                        logic f0, logic f1, zone_e z);
    dir_row_t row;
    row                = mk_item(c0, c1, t);
    row.kind           = RowCheck;
    row.want.fault_ch0 = f0;
    row.want.fault_ch1 = f1;
    row.want.sensor_ok = !(f0 && f1);
    row.want.zone      = z;
    row.want.off_stage = (z != ZoneOnStage);
    return row;
  endfunction

  function automatic dir_row_t mk_write(int unsigned idx, logic [ApbDataBits-1:0] v);
    dir_row_t row;
    row       = '0;
    row.kind  = RowWrite;
    row.reg_i = idx[RegIdxBits-1:0];
    row.arg   = v;
    return row;
  endfunction

  // fills every bit above the register's width with random junk
  function automatic logic [ApbDataBits-1:0] junk_above(logic [ApbDataBits-1:0] v,
                                                        int unsigned bits);
    logic [ApbDataBits-1:0] m;
    m = {ApbDataBits{1'b1}} << bits;
    return (v & ~m) | ({$urandom, $urandom} & m);
  endfunction

  function automatic window_t rand_window();
    window_t     w;
    code_t       a;
    code_t       b;
    code_t       t;
    int unsigned r;
    for (int ch = 0; ch < NumChan; ch++) begin
      a = code_t'($urandom);
      b = code_t'($urandom);
      r = $urandom_range(0, 19);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      if (r < 2) begin
        a = '0;
        b = '1;
      end else if (r < 5) begin
        // min above max: empty window
        t = a;
        a = b;
        b = t;
      end
      w[2*ch*SampleBits +: SampleBits]     = a;
      w[(2*ch+1)*SampleBits +: SampleBits] = b;
    end
    return w;
  endfunction

  // runs of high and low samples so that the timers get to confirm
  function automatic code_t gen_code(int ch);
    int unsigned r;
    int unsigned k;
    code_t       lo;
    code_t       hi;
    code_t       c;
    if (run_left[ch] == 0) begin
      hi_run[ch]   = ($urandom_range(0, 99) < 55);
      run_left[ch] = $urandom_range(1, 8);
    end
    run_left[ch]--;
    r  = $urandom_range(0, 9);
    k  = $urandom_range(0, 2);
    lo = zone_win[k][2*ch*SampleBits +: SampleBits];
    hi = zone_win[k][(2*ch+1)*SampleBits +: SampleBits];
    if (r == 0 || (!hi_run[ch] && level_code == 0)) c = code_t'($urandom);
    else if (hi_run[ch]) c = code_t'($urandom_range(CodeMax, level_code));
    else if (r < 5 && lo <= hi) c = code_t'($urandom_range(hi, lo));
    else c = code_t'($urandom_range(level_code - 1, 0));
    return c;
  endfunction

  function automatic in_item_t gen_item();
    int unsigned r;
    int unsigned span;
    in_item_t    it;
    r    = $urandom_range(0, 19);
    span = (confirm_ms > 200) ? 400 : 2 * confirm_ms + 2;
    if (r == 0) tick = tick + time_t'($urandom);
    else if (r > 3) tick = tick + time_t'($urandom_range(0, span));
    it.sample_ch0 = gen_code(0);
    it.sample_ch1 = gen_code(1);
    it.now_ms     = tick;
    return it;
  endfunction

  task automatic apb_write(int unsigned idx, logic [ApbDataBits-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrBits'(idx * RegStride);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegFaultLevel:  level_code       = data[SampleBits-1:0];
      RegConfirmTime: confirm_ms       = data[TimeBits-1:0];
      RegZoneA:       zone_win[ZoneA]  = data[WindowBits-1:0];
      RegZoneB:       zone_win[ZoneB]  = data[WindowBits-1:0];
      RegZoneC:       zone_win[ZoneC]  = data[WindowBits-1:0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk_i);
  endtask

  // stop offering and wait until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (n_out < n_sent);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic send_item(in_item_t it, logic typed, out_item_t want, int unsigned gap);
    sent_t s;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s.typed = typed;
    s.want  = want;
    sent_q.push_back(s);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!(in_valid_i && in_ready_o));
    n_sent++;
  endtask

  task automatic cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
      n_err++;
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (want_q.size() == 0) begin
      $display("%0t unexpected result: expected none, got %h", $time, got);
      n_err++;
    end else begin
      want = want_q.pop_front();
      cmp_field("fault_ch0", want.fault_ch0, got.fault_ch0);
      cmp_field("fault_ch1", want.fault_ch1, got.fault_ch1);
      cmp_field("sensor_ok", want.sensor_ok, got.sensor_ok);
      cmp_field("zone", want.zone, got.zone);
      cmp_field("off_stage", want.off_stage, got.off_stage);
    end
  endtask

  // transaction monitor: predict on input accept, check on output accept
  always @(posedge clk_i) begin
    sent_t     s;
    out_item_t p;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        s = sent_q.pop_front();
        p = classify(in_data_i);
        want_q.push_back(s.typed ? s.want : p);
      end
      if (out_valid_o && out_ready_i) begin
        check_result(out_data_o);
        n_out++;
        zone_seen[out_data_o.zone]++;
        if (out_data_o.fault_ch0 || out_data_o.fault_ch1) n_fault++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable)) begin
      quiet <= 0;
    end else if (quiet >= WatchdogLimit) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, quiet);
      $display("[dual_sensor_fault_and_zone_classifier] ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // result sink with random stalls and two long hold-offs
  initial begin
    int unsigned rx_done;
    int unsigned gap;
    logic        rx_burst;
    rx_done  = 0;
    rx_burst = 1'b0;
    out_ready_i <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (rx_done % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      if (rx_done == 120 || rx_done == 330) gap = LongHold;
      else if (rx_burst) gap = 0;
      else gap = $urandom_range(0, MaxGap);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
      rx_done++;
    end
  end

  initial begin
    logic        tx_burst;
    code_t       lvl;
    time_t       conf;
    int unsigned r;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_data_i  <= '0;
    psel       <= 1'b0;
    penable    <= 1'b0;
    pwrite     <= 1'b0;
    paddr      <= '0;
    pwdata     <= '0;

    dir_tab = '{
      // reset settings: level at full scale, 1000 ms confirm, all windows at zero
      mk_check(0, 0, 0, 1'b0, 1'b0, ZoneA),
      mk_check(CodeMax, CodeMax, 100, 1'b0, 1'b0, ZoneOnStage),
      mk_check(CodeMax, CodeMax, 1099, 1'b0, 1'b0, ZoneOnStage),
      mk_check(CodeMax, CodeMax, 1100, 1'b1, 1'b1, ZoneOnStage),
      mk_check(CodeMax, 0, 5000, 1'b1, 1'b0, ZoneA),
      mk_check(0, CodeMax, 5001, 1'b0, 1'b0, ZoneOnStage),
      // zero confirm time, junk above the level, an empty window a
      mk_write(RegConfirmTime, 64'h0),
      mk_write(RegFaultLevel, 64'hFFFF_FFFF_FFFF_F800),
      mk_write(RegZoneA, 64'hA5A5_FFF0_0000_0FFF),
      mk_write(RegZoneB, 64'h5A5A_FFF0_007F_F100),
      mk_write(RegZoneC, 64'hFFFF_FFF0_00FF_F000),
      mk_item(12'h800, 12'h7FF, 10),
      mk_item(12'h800, 12'h7FF, 10),
      mk_item(12'h7FF, 12'h000, 11),
      mk_item(CodeMax, CodeMax, 12),
      mk_item(CodeMax, CodeMax, 12),
      mk_write(RegFaultLevel, 64'h0),
      mk_item(0, 0, 20),
      // timer wrap across zero
      mk_write(RegConfirmTime, 64'hFFFF_FFFF_0000_0064),
      mk_write(RegFaultLevel, 64'h800),
      mk_item(0, 0, 32'hFFFF_FFC0),
      mk_item(CodeMax, 0, 32'hFFFF_FFC0),
      mk_item(CodeMax, 0, 32'h0000_0023),
      mk_item(CodeMax, 0, 32'h0000_0024),
      // longest confirm time
      mk_write(RegConfirmTime, 64'hFFFF_FFFF),
      mk_item(12'h800, 12'h800, 0),
      mk_item(12'h800, 12'h800, 32'hFFFF_FFFE),
      mk_item(12'h800, 12'h800, 32'hFFFF_FFFF),
      // writes past the last register must change nothing
      mk_write(NumRegs, '1),
      mk_write(NumRegs + 1, '1),
      mk_write(NumRegs + 2, '1),
      mk_item(12'h5A5, 12'hA5A, 32'h5A5A_A5A5),
      mk_item(CodeMax, CodeMax, 32'hFFFF_FFFF)
    };

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == RowWrite) begin
        wait_drained();
        apb_write(dir_tab[i].reg_i, dir_tab[i].arg);
      end else begin
        send_item(dir_tab[i].item, dir_tab[i].kind == RowCheck, dir_tab[i].want,
                  $urandom_range(0, MaxGap));
      end
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      wait_drained();
      r = $urandom_range(0, 9);
      if (phase == 0) begin
        lvl  = '0;
        conf = '0;
      end else if (phase == 1) begin
        lvl  = '1;
        conf = '1;
      end else begin
        lvl  = (r == 0) ? code_t'(0) : (r == 1) ? code_t'(CodeMax) :
               code_t'($urandom_range(12'hE00, 12'h200));
        r    = $urandom_range(0, 19);
        conf = (r < 3) ? time_t'(0) : (r < 5) ? time_t'($urandom) :
               time_t'($urandom_range(150, 1));
      end
      apb_write(RegFaultLevel, junk_above(ApbDataBits'(lvl), SampleBits));
      apb_write(RegConfirmTime, junk_above(ApbDataBits'(conf), TimeBits));
      apb_write(RegZoneA, junk_above(ApbDataBits'(rand_window()), WindowBits));
      apb_write(RegZoneB, junk_above(ApbDataBits'(rand_window()), WindowBits));
      apb_write(RegZoneC, junk_above(ApbDataBits'(rand_window()), WindowBits));
      tick     = time_t'($urandom);
      tx_burst = (phase % 3 == 1);
      for (int i = 0; i < PhaseItems; i++) begin
        send_item(gen_item(), 1'b0, '0, tx_burst ? 0 : $urandom_range(0, MaxGap));
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (want_q.size() != 0) begin
      $display("%0t %0d expected results never arrived", $time, want_q.size());
      n_err++;
    end
    $display("run covered %0d sample pairs, %0d results, %0d register writes, %0d with a fault",
             n_sent, n_out, n_cfg, n_fault);
    $display("zone a %0d, zone b %0d, zone c %0d, on-stage %0d; %0d mismatches",
             zone_seen[ZoneA], zone_seen[ZoneB], zone_seen[ZoneC], zone_seen[ZoneOnStage],
             n_err);
    if (n_err == 0) begin
      $display("[dual_sensor_fault_and_zone_classifier] OK");
    end else begin
      $display("[dual_sensor_fault_and_zone_classifier] ERROR");
    end
    $finish;
  end

endmodule
